FILE: rtl/kvsp_pkg.sv
// kvsp_pkg: shared types and constants for the snapshot stream parser.
// No dependencies; used by kvsp_step and kv_snapshot_stream_parser_unit.
`timescale 1ns / 1ps

package kvsp_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC   = 5'd0,
    PH_OPCODE  = 5'd1,
    PH_DBLEN   = 5'd2,
    PH_DBLEN2  = 5'd3,
    PH_TYPE    = 5'd4,
    PH_KEYLEN  = 5'd5,
    PH_KEYLEN2 = 5'd6,
    PH_KEY     = 5'd7,
    PH_VALLEN  = 5'd8,
    PH_VALLEN2 = 5'd9,
    PH_VAL     = 5'd10,
    PH_CNTLEN  = 5'd11,
    PH_CNTLEN2 = 5'd12,
    PH_FLDLEN  = 5'd13,
    PH_FLDLEN2 = 5'd14,
    PH_FLD     = 5'd15,
    PH_FVLEN   = 5'd16,
    PH_FVLEN2  = 5'd17,
    PH_FV      = 5'd18,
    PH_CHECK   = 5'd19,
    PH_DONE    = 5'd20,
    PH_ERROR   = 5'd21
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_MAGIC    = 4'd0,
    ROLE_DB       = 4'd1,
    ROLE_LENGTH   = 4'd2,
    ROLE_TYPE     = 4'd3,
    ROLE_KEY      = 4'd4,
    ROLE_VALUE    = 4'd5,
    ROLE_FIELD    = 4'd6,
    ROLE_FVALUE   = 4'd7,
    ROLE_END      = 4'd8,
    ROLE_CHECKSUM = 4'd9,
    ROLE_IGNORED  = 4'd10,
    ROLE_ERROR    = 4'd11
  } role_t;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_TYPE    = 3'd5,
    ST_TRUNC   = 3'd6
  } status_t;

  localparam logic [7:0] OP_SELECT_DB = 8'hFE;
  localparam logic [7:0] OP_EOF       = 8'hFF;
  localparam logic [7:0] TYPE_STRING  = 8'h00;
  localparam logic [7:0] TYPE_HASH    = 8'h02;
  localparam logic [1:0] PFX_SHORT    = 2'b00;
  localparam logic [1:0] PFX_LONG     = 2'b01;
  localparam logic [3:0] HDR_LAST     = 4'd8;
  localparam logic [3:0] MAGIC_BYTES  = 4'd5;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  magic_pos;
    logic [13:0] len_rem;
    logic [5:0]  len_high;
    logic [13:0] pairs_rem;
    logic [13:0] pair_cnt;
    logic        kind;
    logic [3:0]  chk_cnt;
    status_t     status;
  } state_t;

  typedef struct packed {
    role_t       role;
    logic        kind;
    logic        last;
    logic        done;
    logic [13:0] pair;
    status_t     status;
  } result_t;

  // "REDIS0009"
  function automatic logic [7:0] header_byte(input logic [3:0] pos);
    case (pos)
      4'd0:    header_byte = 8'h52;
      4'd1:    header_byte = 8'h45;
      4'd2:    header_byte = 8'h44;
      4'd3:    header_byte = 8'h49;
      4'd4:    header_byte = 8'h53;
      4'd5:    header_byte = 8'h30;
      4'd6:    header_byte = 8'h30;
      4'd7:    header_byte = 8'h30;
      4'd8:    header_byte = 8'h39;
      default: header_byte = 8'h00;
    endcase
  endfunction

endpackage

FILE: rtl/kvsp_step.sv
// kvsp_step: next-state and byte classification for one stream byte.
// Purely combinational; depends on kvsp_pkg.
`timescale 1ns / 1ps

module kvsp_step (
  input  kvsp_pkg::state_t  st,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output kvsp_pkg::state_t  nx,
  output kvsp_pkg::result_t res
);
  import kvsp_pkg::*;

  state_t      s;
  role_t       role;
  logic        last;
  logic        done;
  logic        len_fire;
  phase_t      len_slot;
  logic [13:0] len_val;
  logic        str_fire;
  phase_t      str_slot;
  logic [13:0] rem_dec;
  logic [13:0] pairs_dec;
  logic [3:0]  chk_inc;

  assign rem_dec   = st.len_rem - 14'd1;
  assign pairs_dec = st.pairs_rem - 14'd1;
  assign chk_inc   = st.chk_cnt + 4'd1;

  always_comb begin
    s        = st;
    role     = ROLE_ERROR;
    last     = 1'b0;
    done     = 1'b0;
    len_fire = 1'b0;
    len_slot = PH_KEYLEN;
    len_val  = 14'd0;
    str_fire = 1'b0;
    str_slot = PH_KEYLEN;

    case (st.phase)
      PH_OPCODE, PH_TYPE: begin
        if (st.phase == PH_OPCODE && data_byte == OP_SELECT_DB) begin
          role    = ROLE_DB;
          s.phase = PH_DBLEN;
        end else if (data_byte == OP_EOF) begin
          role      = ROLE_END;
          s.chk_cnt = 4'd0;
          s.phase   = PH_CHECK;
        end else if (data_byte == TYPE_STRING || data_byte == TYPE_HASH) begin
          role       = ROLE_TYPE;
          s.kind     = (data_byte == TYPE_HASH);
          s.pair_cnt = 14'd0;
          s.phase    = PH_KEYLEN;
        end else begin
          s.status = ST_TYPE;
          s.phase  = PH_ERROR;
        end
      end
      PH_MAGIC: begin
        if (st.magic_pos > HDR_LAST || header_byte(st.magic_pos) != data_byte) begin
          s.status = (st.magic_pos < MAGIC_BYTES) ? ST_MAGIC : ST_VERSION;
          s.phase  = PH_ERROR;
        end else begin
          role        = ROLE_MAGIC;
          s.magic_pos = st.magic_pos + 4'd1;
          if (st.magic_pos == HDR_LAST) s.phase = PH_OPCODE;
        end
      end
      PH_DBLEN, PH_KEYLEN, PH_VALLEN, PH_CNTLEN, PH_FLDLEN, PH_FVLEN: begin
        if (data_byte[7:6] == PFX_SHORT) begin
          role     = ROLE_LENGTH;
          len_fire = 1'b1;
          len_slot = st.phase;
          len_val  = {8'd0, data_byte[5:0]};
        end else if (data_byte[7:6] == PFX_LONG) begin
          role       = ROLE_LENGTH;
          s.len_high = data_byte[5:0];
          s.phase    = phase_t'(st.phase + 5'd1);
        end else begin
          s.status = ST_LENGTH;
          s.phase  = PH_ERROR;
        end
      end
      PH_DBLEN2, PH_KEYLEN2, PH_VALLEN2, PH_CNTLEN2, PH_FLDLEN2, PH_FVLEN2: begin
        role     = ROLE_LENGTH;
        len_fire = 1'b1;
        len_slot = phase_t'(st.phase - 5'd1);
        len_val  = {st.len_high, data_byte};
      end
      PH_KEY, PH_VAL, PH_FLD, PH_FV: begin
        case (st.phase)
          PH_KEY:  role = ROLE_KEY;
          PH_VAL:  role = ROLE_VALUE;
          PH_FLD:  role = ROLE_FIELD;
          default: role = ROLE_FVALUE;
        endcase
        s.len_rem = rem_dec;
        if (rem_dec == 14'd0) begin
          last     = 1'b1;
          str_fire = 1'b1;
          str_slot = phase_t'(st.phase - 5'd2);
        end
      end
      PH_CHECK: begin
        role      = ROLE_CHECKSUM;
        s.chk_cnt = chk_inc;
        if (chk_inc[3]) begin
          s.status = ST_DONE;
          s.phase  = PH_DONE;
        end
      end
      PH_DONE: begin
        role = ROLE_IGNORED;
      end
      default: begin
        role = ROLE_ERROR;
        if (st.status == ST_RUN) s.status = ST_TRUNC;
        s.phase = PH_ERROR;
      end
    endcase

    // length complete
    if (len_fire) begin
      case (len_slot)
        PH_DBLEN: begin
          s.phase = (len_val == 14'd0) ? PH_TYPE : PH_OPCODE;
        end
        PH_CNTLEN: begin
          s.pairs_rem = len_val;
          if (len_val == 14'd0) begin
            s.phase = PH_TYPE;
            done    = 1'b1;
          end else begin
            s.phase = PH_FLDLEN;
          end
        end
        default: begin
          s.len_rem = len_val;
          if (len_val == 14'd0) begin
            str_fire = 1'b1;
            str_slot = len_slot;
          end else begin
            s.phase = phase_t'(len_slot + 5'd2);
          end
        end
      endcase
    end

    // string complete
    if (str_fire) begin
      case (str_slot)
        PH_KEYLEN: s.phase = st.kind ? PH_CNTLEN : PH_VALLEN;
        PH_VALLEN: begin
          s.phase = PH_TYPE;
          done    = 1'b1;
        end
        PH_FLDLEN: s.phase = PH_FVLEN;
        default: begin
          s.pairs_rem = pairs_dec;
          if (pairs_dec == 14'd0) begin
            s.phase = PH_TYPE;
            done    = 1'b1;
          end else begin
            s.pair_cnt = st.pair_cnt + 14'd1;
            s.phase    = PH_FLDLEN;
          end
        end
      endcase
    end

    // source ran out
    if (stream_end && s.status == ST_RUN) begin
      if (s.phase == PH_CHECK) begin
        s.status = ST_DONE;
        s.phase  = PH_DONE;
      end else begin
        s.status = ST_TRUNC;
        s.phase  = PH_ERROR;
      end
    end
  end

  assign nx         = s;
  assign res.role   = role;
  assign res.kind   = s.kind;
  assign res.last   = last;
  assign res.done   = done;
  assign res.pair   = s.pair_cnt;
  assign res.status = s.status;

endmodule

FILE: rtl/kv_snapshot_stream_parser_unit.sv
// kv_snapshot_stream_parser_unit: top level of the snapshot stream parser.
// Input register, parser state register and result register; uses kvsp_pkg, kvsp_step.
`timescale 1ns / 1ps
// A beat accepted into the input register is classified into the result register
// when that register is empty or being drained; out_stall can hold it in between.
// Throughput: one byte per cycle unless out_stall holds the result register; kvsp_step is combinational.
// Reset (rst, synchronous): parser waits for the header, status running, both
// pipeline registers empty.

module kv_snapshot_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  byte_role,
  output logic [7:0]  byte_out,
  output logic        record_kind,
  output logic        string_last,
  output logic        record_done,
  output logic [13:0] pair_number,
  output logic [2:0]  status
);
  import kvsp_pkg::*;

  // input register
  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_end;

  // parser state
  state_t      st;
  state_t      st_next;
  result_t     res;

  logic        advance;
  logic        in_take;

  // A beat in the input register moves on when the result register is
  // empty or is being drained this cycle.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  kvsp_step u_step (
    .st         (st),
    .data_byte  (in_byte),
    .stream_end (in_end),
    .nx         (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= data_byte;
      in_end  <= stream_end;
    end
  end

  // Parser state only moves when a beat is actually classified.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_MAGIC;
      st.magic_pos <= 4'd0;
      st.len_rem   <= 14'd0;
      st.len_high  <= 6'd0;
      st.pairs_rem <= 14'd0;
      st.pair_cnt  <= 14'd0;
      st.kind      <= 1'b0;
      st.chk_cnt   <= 4'd0;
      st.status    <= ST_RUN;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_role   <= res.role;
      byte_out    <= in_byte;
      record_kind <= res.kind;
      string_last <= res.last;
      record_done <= res.done;
      pair_number <= res.pair;
      status      <= res.status;
    end
  end

endmodule
